@@ design/wal_pkg.sv @@
// ----------------------------------------------------------------------------
// wal_pkg: shared types and codes of the write-ahead log tracker
// Holds the table depth, the request, status and command codes, and the
// command and status structs exchanged by the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package wal_pkg;

  // Number of entries in the logged-block table.
  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  // Register indexes on the configuration channel.
  localparam logic [1:0] REG_LOG_START = 2'd0;
  localparam logic [1:0] REG_LOG_SIZE  = 2'd1;
  localparam logic [1:0] REG_MAX_OP    = 2'd2;
  localparam logic [1:0] REG_HDR_BLKS  = 2'd3;

  // Request opcodes.
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_WAIT        = 3'd1;
  localparam logic [2:0] ST_END_NO_BEG  = 3'd2;
  localparam logic [2:0] ST_NO_TXN      = 3'd3;
  localparam logic [2:0] ST_LOG_FULL    = 3'd4;

  // Device command codes.
  localparam logic [2:0] CMD_NONE      = 3'd0;
  localparam logic [2:0] CMD_COPY      = 3'd1;
  localparam logic [2:0] CMD_HDR_WRITE = 3'd2;
  localparam logic [2:0] CMD_INSTALL   = 3'd3;
  localparam logic [2:0] CMD_HDR_CLEAR = 3'd4;

  // Kind of result word the datapath builds.
  localparam logic [2:0] RES_SINGLE  = 3'd0;
  localparam logic [2:0] RES_COPY    = 3'd1;
  localparam logic [2:0] RES_HDR     = 3'd2;
  localparam logic [2:0] RES_INSTALL = 3'd3;
  localparam logic [2:0] RES_CLEAR   = 3'd4;

  // Controller to datapath commands.
  typedef struct packed {
    logic       latch_in;
    logic       rd_en;
    logic       idx_clr;
    logic       idx_inc;
    logic       open_inc;
    logic       open_dec;
    logic       tbl_wr;
    logic       count_clr;
    logic       load_out;
    logic [2:0] res_kind;
    logic [2:0] res_status;
    logic       res_pin;
  } wal_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [1:0] opcode;
    logic       open_zero;
    logic       open_one;
    logic       begin_wait;
    logic       write_full;
    logic       count_zero;
    logic       match;
    logic       idx_last;
    logic       out_free;
  } wal_sts_t;

endpackage

`default_nettype wire

@@ design/wal_ram.sv @@
// ----------------------------------------------------------------------------
// wal_ram: generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module wal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                             wr_data,
  input  wire logic                                         rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while no new read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ design/wal_datapath.sv @@
// ----------------------------------------------------------------------------
// wal_datapath: registers, table and result word of the log tracker
// Holds the configuration registers, the open-operation and entry counters,
// the logged-block table, the walk index and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wal_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Configuration writes.
  input  wire logic              cfg_wr,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  // Request word.
  input  wire logic [1:0]        in_opcode,
  input  wire logic [31:0]       in_block_number,
  // Controller interface.
  input  wire wal_pkg::wal_cmd_t cmd,
  output wal_pkg::wal_sts_t      sts,
  // Result channel.
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             out_status,
  output logic [2:0]             out_command,
  output logic [31:0]            out_src_block,
  output logic [31:0]            out_dst_block,
  output logic [4:0]             out_entry_count,
  output logic                   out_pin_new,
  output logic                   out_unpin,
  output logic                   out_last
);

  // Configuration registers.
  logic [31:0] log_start_r;
  logic [6:0]  log_size_r;
  logic [5:0]  max_op_r;
  logic [2:0]  hdr_blocks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_start_r  <= 32'd2;
      log_size_r   <= 7'd31;
      max_op_r     <= 6'd10;
      hdr_blocks_r <= 3'd1;
    end else if (cfg_wr) begin
      case (cfg_index)
        wal_pkg::REG_LOG_START: log_start_r  <= cfg_data;
        wal_pkg::REG_LOG_SIZE:  log_size_r   <= cfg_data[6:0];
        wal_pkg::REG_MAX_OP:    max_op_r     <= cfg_data[5:0];
        wal_pkg::REG_HDR_BLKS:  hdr_blocks_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Latched request.
  logic [1:0]  op_r;
  logic [31:0] blk_r;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r  <= in_opcode;
      blk_r <= in_block_number;
    end
  end

  // Counters and walk index.
  logic [5:0]      open_r;
  wal_pkg::cnt_t   count_r;
  wal_pkg::idx_t   idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.open_inc) begin
        open_r <= open_r + 6'd1;
      end else if (cmd.open_dec) begin
        open_r <= open_r - 6'd1;
      end
      if (cmd.count_clr) begin
        count_r <= '0;
      end else if (cmd.tbl_wr) begin
        count_r <= count_r + wal_pkg::cnt_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + wal_pkg::idx_t'(1);
    end
  end

  // Logged-block table.
  logic [31:0] rd_data;

  wal_ram #(
    .WIDTH (32),
    .DEPTH (wal_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (cmd.tbl_wr),
    .wr_addr (count_r[wal_pkg::IDX_W-1:0]),
    .wr_data (blk_r),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r),
    .rd_data (rd_data)
  );

  // Space checks: data area is log size less header blocks, may be negative.
  logic signed [14:0] area_s;
  logic signed [14:0] count_s;
  logic        [12:0] need_prod;
  logic signed [14:0] need_s;

  assign area_s    = $signed({8'd0, log_size_r}) - $signed({12'd0, hdr_blocks_r});
  assign count_s   = $signed(15'(count_r));
  assign need_prod = 13'({1'b0, open_r} + 7'd1) * 13'(max_op_r);
  assign need_s    = count_s + $signed({2'b00, need_prod});

  // Status toward the controller.
  logic out_valid_r;

  always_comb begin
    sts.opcode     = op_r;
    sts.open_zero  = (open_r == 6'd0);
    sts.open_one   = (open_r == 6'd1);
    sts.begin_wait = (open_r == 6'd63) || (need_s > area_s);
    sts.write_full = (count_r >= wal_pkg::cnt_t'(wal_pkg::TABLE_DEPTH)) ||
                     (count_s >= area_s);
    sts.count_zero = (count_r == '0);
    sts.match      = (rd_data == blk_r);
    sts.idx_last   = ((wal_pkg::cnt_t'(idx_r) + wal_pkg::cnt_t'(1)) == count_r);
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // Log slot addresses.
  logic [31:0] slot_addr;
  assign slot_addr = log_start_r + 32'(hdr_blocks_r) + 32'(idx_r);

  // Result word construction.
  logic [2:0]  status_nxt;
  logic [2:0]  command_nxt;
  logic [31:0] src_nxt;
  logic [31:0] dst_nxt;
  logic [4:0]  ecount_nxt;
  logic        pin_nxt;
  logic        unpin_nxt;
  logic        last_nxt;

  always_comb begin
    status_nxt  = wal_pkg::ST_OK;
    command_nxt = wal_pkg::CMD_NONE;
    src_nxt     = '0;
    dst_nxt     = '0;
    ecount_nxt  = '0;
    pin_nxt     = 1'b0;
    unpin_nxt   = 1'b0;
    last_nxt    = 1'b0;
    case (cmd.res_kind)
      wal_pkg::RES_COPY: begin
        command_nxt = wal_pkg::CMD_COPY;
        src_nxt     = rd_data;
        dst_nxt     = slot_addr;
      end
      wal_pkg::RES_HDR: begin
        command_nxt = wal_pkg::CMD_HDR_WRITE;
        dst_nxt     = log_start_r;
        ecount_nxt  = 5'(count_r);
      end
      wal_pkg::RES_INSTALL: begin
        command_nxt = wal_pkg::CMD_INSTALL;
        src_nxt     = slot_addr;
        dst_nxt     = rd_data;
        unpin_nxt   = 1'b1;
      end
      wal_pkg::RES_CLEAR: begin
        command_nxt = wal_pkg::CMD_HDR_CLEAR;
        dst_nxt     = log_start_r;
        last_nxt    = 1'b1;
      end
      default: begin
        status_nxt = cmd.res_status;
        pin_nxt    = cmd.res_pin;
        last_nxt   = 1'b1;
      end
    endcase
  end

  // Output register.
  logic [2:0]  status_r;
  logic [2:0]  command_r;
  logic [31:0] src_r;
  logic [31:0] dst_r;
  logic [4:0]  ecount_r;
  logic        pin_r;
  logic        unpin_r;
  logic        last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r  <= status_nxt;
      command_r <= command_nxt;
      src_r     <= src_nxt;
      dst_r     <= dst_nxt;
      ecount_r  <= ecount_nxt;
      pin_r     <= pin_nxt;
      unpin_r   <= unpin_nxt;
      last_r    <= last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_command     = command_r;
  assign out_src_block   = src_r;
  assign out_dst_block   = dst_r;
  assign out_entry_count = ecount_r;
  assign out_pin_new     = pin_r;
  assign out_unpin       = unpin_r;
  assign out_last        = last_r;

endmodule

`default_nettype wire

@@ design/wal_ctrl.sv @@
// ----------------------------------------------------------------------------
// wal_ctrl: controller of the log tracker
// Sequences request decode, the duplicate search over the table and the
// commit run, and paces result words against the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wal_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire wal_pkg::wal_sts_t sts,
  output wal_pkg::wal_cmd_t      cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_SRCH    = 4'd2;
  localparam logic [3:0] S_SCMP    = 4'd3;
  localparam logic [3:0] S_NEW     = 4'd4;
  localparam logic [3:0] S_CP_RD   = 4'd5;
  localparam logic [3:0] S_CP_EMIT = 4'd6;
  localparam logic [3:0] S_HDR     = 4'd7;
  localparam logic [3:0] S_IN_RD   = 4'd8;
  localparam logic [3:0] S_IN_EMIT = 4'd9;
  localparam logic [3:0] S_CLR     = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_kind   = wal_pkg::RES_SINGLE;
    cmd.res_status = wal_pkg::ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.opcode)
          wal_pkg::OP_BEGIN: begin
            if (sts.out_free) begin
              cmd.load_out   = 1'b1;
              cmd.res_status = sts.begin_wait ? wal_pkg::ST_WAIT : wal_pkg::ST_OK;
              cmd.open_inc   = !sts.begin_wait;
              state_nxt      = S_IDLE;
            end
          end
          wal_pkg::OP_END: begin
            if (sts.open_zero) begin
              if (sts.out_free) begin
                cmd.load_out   = 1'b1;
                cmd.res_status = wal_pkg::ST_END_NO_BEG;
                state_nxt      = S_IDLE;
              end
            end else if (sts.open_one && !sts.count_zero) begin
              // Last operation closed with entries logged: start the commit run.
              cmd.open_dec = 1'b1;
              cmd.idx_clr  = 1'b1;
              state_nxt    = S_CP_RD;
            end else if (sts.out_free) begin
              cmd.open_dec = 1'b1;
              cmd.load_out = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          wal_pkg::OP_WRITE: begin
            if (sts.write_full) begin
              if (sts.out_free) begin
                cmd.load_out   = 1'b1;
                cmd.res_status = wal_pkg::ST_LOG_FULL;
                state_nxt      = S_IDLE;
              end
            end else if (sts.open_zero) begin
              if (sts.out_free) begin
                cmd.load_out   = 1'b1;
                cmd.res_status = wal_pkg::ST_NO_TXN;
                state_nxt      = S_IDLE;
              end
            end else if (sts.count_zero) begin
              state_nxt = S_NEW;
            end else begin
              cmd.idx_clr = 1'b1;
              state_nxt   = S_SRCH;
            end
          end
          default: begin
            if (sts.out_free) begin
              cmd.load_out = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
        endcase
      end
      // Duplicate search: read one entry, then compare it.
      S_SRCH: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SCMP;
      end
      S_SCMP: begin
        if (sts.match) begin
          if (sts.out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else if (sts.idx_last) begin
          state_nxt = S_NEW;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SRCH;
        end
      end
      // New entry: append to the table and report the pin.
      S_NEW: begin
        if (sts.out_free) begin
          cmd.tbl_wr   = 1'b1;
          cmd.load_out = 1'b1;
          cmd.res_pin  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      // Commit run, copy phase.
      S_CP_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_CP_EMIT;
      end
      S_CP_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.res_kind = wal_pkg::RES_COPY;
          if (sts.idx_last) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_HDR;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_CP_RD;
          end
        end
      end
      S_HDR: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.res_kind = wal_pkg::RES_HDR;
          state_nxt    = S_IN_RD;
        end
      end
      // Commit run, install phase.
      S_IN_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_IN_EMIT;
      end
      S_IN_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.res_kind = wal_pkg::RES_INSTALL;
          if (sts.idx_last) begin
            state_nxt = S_CLR;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_IN_RD;
          end
        end
      end
      S_CLR: begin
        if (sts.out_free) begin
          cmd.load_out  = 1'b1;
          cmd.res_kind  = wal_pkg::RES_CLEAR;
          cmd.count_clr = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/write_ahead_log_tracker.sv @@
// ----------------------------------------------------------------------------
// write_ahead_log_tracker: journal transaction tracker with group commit
// Takes begin, end and block-write requests and answers with status words
// and, on the final end of a transaction, a run of device commands.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ channel (valid/stall); result words leave on
//   the out_ channel (valid/stall) and every request's final word has
//   out_last set. Registers are written on the cfg_ channel (valid/ready,
//   always ready); the user must do so only while the block is idle, as the
//   block itself does not enforce it. A request is taken in S_IDLE and decoded
//   in the next cycle; S_DECODE loads a single-word answer into the output
//   register once the output is free. A write with n logged entries walks the
//   table entry by entry (one read of its registered port, one compare) and
//   stops at a match. An end that commits n entries emits 2n+2 words; each
//   copy and install word takes a table read and then an emit, and the header
//   words are emitted directly. One request is in work at a time, and a new
//   one is taken in the cycle after its predecessor's last word is loaded.
//   Reset clears the counters, the control and the output valid, and loads the
//   register defaults; table contents are not cleared. A stalled output word
//   holds, and the controller waits before loading the next word.
// ----------------------------------------------------------------------------
`default_nettype none

module write_ahead_log_tracker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  // Request channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [31:0] in_block_number,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [2:0]       out_command,
  output logic [31:0]      out_src_block,
  output logic [31:0]      out_dst_block,
  output logic [4:0]       out_entry_count,
  output logic             out_pin_new,
  output logic             out_unpin,
  output logic             out_last
);

  wal_pkg::wal_cmd_t cmd;
  wal_pkg::wal_sts_t sts;

  assign cfg_ready = 1'b1;

  // Controller.
  wal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  wal_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_opcode       (in_opcode),
    .in_block_number (in_block_number),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_command     (out_command),
    .out_src_block   (out_src_block),
    .out_dst_block   (out_dst_block),
    .out_entry_count (out_entry_count),
    .out_pin_new     (out_pin_new),
    .out_unpin       (out_unpin),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

@@ tb/write_ahead_log_tracker_tb.sv @@
// ----------------------------------------------------------------------------
// write_ahead_log_tracker_tb: self-checking bench for the journal tracker
// Drives begin, end and block-write requests under several register settings.
// A built-in transaction tracker predicts every result word, including whole
// commit runs. Each word the block hands out is checked field by field
// against the oldest prediction. Random gaps on the request side and random
// stalls on the result side move the timing around.
// ----------------------------------------------------------------------------
module write_ahead_log_tracker_tb;

  // Opcode that the block answers with a plain ok word.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int OPEN_LIMIT    = 63;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 30;

  // One result word as the tracker predicts it.
  typedef struct {
    logic [2:0]  status;
    logic [2:0]  command;
    logic [31:0] src_block;
    logic [31:0] dst_block;
    logic [4:0]  entry_count;
    logic        pin_new;
    logic        unpin;
    logic        last;
  } log_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = '0;
  logic [31:0] in_block_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [2:0]  out_command;
  logic [31:0] out_src_block;
  logic [31:0] out_dst_block;
  logic [4:0]  out_entry_count;
  logic        out_pin_new;
  logic        out_unpin;
  logic        out_last;

  write_ahead_log_tracker uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_block_number (in_block_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_command     (out_command),
    .out_src_block   (out_src_block),
    .out_dst_block   (out_dst_block),
    .out_entry_count (out_entry_count),
    .out_pin_new     (out_pin_new),
    .out_unpin       (out_unpin),
    .out_last        (out_last)
  );

  // Register copies, starting from the reset defaults.
  logic [31:0] reg_log_start = 32'd2;
  logic [6:0]  reg_log_size  = 7'd31;
  logic [5:0]  reg_max_op    = 6'd10;
  logic [2:0]  reg_hdr_blks  = 3'd1;

  // Tracker state: logged home blocks, entries in use, open operations.
  logic [31:0] jr_blocks [wal_pkg::TABLE_DEPTH];
  int          jr_count = 0;
  int          jr_open = 0;

  log_word_t   pending_words [$];

  int err_count = 0;
  int items_sent = 0;
  int words_seen = 0;
  int commit_runs = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  always #5 clk = ~clk;

  // Idle stretch length: mostly short, now and then long.
  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic void queue_word(input logic [2:0] status, input logic [2:0] command,
                                     input logic [31:0] src, input logic [31:0] dst,
                                     input logic [4:0] cnt, input logic pin,
                                     input logic unpin, input logic last);
    log_word_t w;
    w.status      = status;
    w.command     = command;
    w.src_block   = src;
    w.dst_block   = dst;
    w.entry_count = cnt;
    w.pin_new     = pin;
    w.unpin       = unpin;
    w.last        = last;
    pending_words.push_back(w);
  endfunction

  // Predict the words of one accepted request and advance the tracker state.
  function automatic void track_request(input logic [1:0] op, input logic [31:0] blk);
    int          area;
    int          need;
    logic [31:0] slot0;
    bit          dup;
    area = int'(reg_log_size) - int'(reg_hdr_blks);
    dup = 1'b0;
    case (op)
      wal_pkg::OP_BEGIN: begin
        // Wait when the pending log plus worst case for every open operation overflows.
        need = jr_count + (jr_open + 1) * int'(reg_max_op);
        if (jr_open >= OPEN_LIMIT || need > area) begin
          queue_word(wal_pkg::ST_WAIT, wal_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          jr_open++;
          queue_word(wal_pkg::ST_OK, wal_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
        end
      end
      wal_pkg::OP_END: begin
        if (jr_open == 0) begin
          queue_word(wal_pkg::ST_END_NO_BEG, wal_pkg::CMD_NONE, '0, '0, '0,
                     1'b0, 1'b0, 1'b1);
        end else begin
          jr_open--;
          if (jr_open != 0 || jr_count == 0) begin
            queue_word(wal_pkg::ST_OK, wal_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
          end else begin
            // Last operation closed with entries logged: full commit run.
            slot0 = reg_log_start + 32'(reg_hdr_blks);
            for (int i = 0; i < jr_count; i++)
              queue_word(wal_pkg::ST_OK, wal_pkg::CMD_COPY, jr_blocks[i],
                         slot0 + 32'(i), '0, 1'b0, 1'b0, 1'b0);
            queue_word(wal_pkg::ST_OK, wal_pkg::CMD_HDR_WRITE, '0, reg_log_start,
                       5'(jr_count), 1'b0, 1'b0, 1'b0);
            for (int i = 0; i < jr_count; i++)
              queue_word(wal_pkg::ST_OK, wal_pkg::CMD_INSTALL, slot0 + 32'(i),
                         jr_blocks[i], '0, 1'b0, 1'b1, 1'b0);
            queue_word(wal_pkg::ST_OK, wal_pkg::CMD_HDR_CLEAR, '0, reg_log_start, '0,
                       1'b0, 1'b0, 1'b1);
            jr_count = 0;
            commit_runs++;
          end
        end
      end
      wal_pkg::OP_WRITE: begin
        // The full check comes ahead of the transaction check and the search.
        if (jr_count >= wal_pkg::TABLE_DEPTH || jr_count >= area) begin
          queue_word(wal_pkg::ST_LOG_FULL, wal_pkg::CMD_NONE, '0, '0, '0,
                     1'b0, 1'b0, 1'b1);
        end else if (jr_open == 0) begin
          queue_word(wal_pkg::ST_NO_TXN, wal_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < jr_count; i++)
            if (jr_blocks[i] == blk) dup = 1'b1;
          if (dup) begin
            queue_word(wal_pkg::ST_OK, wal_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
          end else begin
            jr_blocks[jr_count] = blk;
            jr_count++;
            queue_word(wal_pkg::ST_OK, wal_pkg::CMD_NONE, '0, '0, '0, 1'b1, 1'b0, 1'b1);
          end
        end
      end
      default: begin
        queue_word(wal_pkg::ST_OK, wal_pkg::CMD_NONE, '0, '0, '0, 1'b0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  // Send one request word, with an optional gap in front of it.
  task automatic send_request(input logic [1:0] op, input logic [31:0] blk);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_block_number <= blk;
    do @(posedge clk); while (in_stall);
    track_request(op, blk);
    items_sent++;
  endtask

  // Hold off new requests until every predicted word has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      wal_pkg::REG_LOG_START: reg_log_start = data;
      wal_pkg::REG_LOG_SIZE:  reg_log_size = data[6:0];
      wal_pkg::REG_MAX_OP:    reg_max_op = data[5:0];
      wal_pkg::REG_HDR_BLKS:  reg_hdr_blks = data[2:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] start, input int size, input int max_op,
                            input int hdr);
    write_reg(wal_pkg::REG_LOG_START, start);
    write_reg(wal_pkg::REG_LOG_SIZE, 32'(size));
    write_reg(wal_pkg::REG_MAX_OP, 32'(max_op));
    write_reg(wal_pkg::REG_HDR_BLKS, 32'(hdr));
  endtask

  // Block number for a write: often one already logged, sometimes an extreme.
  function automatic logic [31:0] pick_block();
    if (jr_count > 0 && $urandom_range(0, 2) == 0)
      return jr_blocks[$urandom_range(0, jr_count - 1)];
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Reset settings: error answers, unused opcode, waits, duplicates, commits.
  task automatic test_defaults();
    send_request(wal_pkg::OP_END, 32'h0);
    send_request(wal_pkg::OP_WRITE, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 32'hFFFF_FFFF);
    send_request(wal_pkg::OP_BEGIN, 32'h0);
    send_request(wal_pkg::OP_END, 32'h0);
    repeat (4) send_request(wal_pkg::OP_BEGIN, $urandom);
    send_request(wal_pkg::OP_WRITE, 32'h0000_0000);
    send_request(wal_pkg::OP_WRITE, 32'hFFFF_FFFF);
    send_request(wal_pkg::OP_WRITE, 32'h0000_0000);
    repeat (3) send_request(wal_pkg::OP_END, $urandom);
  endtask

  // Data area below zero, then a tiny log that fills and wraps its slots.
  task automatic test_wait_and_full();
    drain_results();
    set_config(32'h0000_0000, 2, 63, 4);
    send_request(wal_pkg::OP_BEGIN, 32'h0);
    send_request(wal_pkg::OP_WRITE, 32'h5);
    send_request(wal_pkg::OP_END, 32'h0);
    drain_results();
    set_config(32'hFFFF_FFFF, 8, 3, 1);
    repeat (3) send_request(wal_pkg::OP_BEGIN, 32'h0);
    repeat (7) send_request(wal_pkg::OP_WRITE, $urandom);
    send_request(wal_pkg::OP_WRITE, jr_blocks[0]);
    repeat (2) send_request(wal_pkg::OP_END, 32'h0);
    send_request(OP_UNUSED, 32'h0);
  endtask

  // Fill the whole table, overflow it, and commit the longest run.
  task automatic test_table_depth();
    logic [31:0] base;
    base = $urandom;
    drain_results();
    set_config($urandom, 64, 1, 1);
    send_request(wal_pkg::OP_BEGIN, 32'h0);
    for (int i = 0; i < wal_pkg::TABLE_DEPTH; i++)
      send_request(wal_pkg::OP_WRITE, base + 32'(i));
    send_request(wal_pkg::OP_WRITE, base + 32'(wal_pkg::TABLE_DEPTH));
    send_request(wal_pkg::OP_END, 32'h0);
  endtask

  // Open operations up to the counter's ceiling, then close them all.
  task automatic test_open_saturation();
    drain_results();
    repeat (OPEN_LIMIT + 1) send_request(wal_pkg::OP_BEGIN, $urandom);
    send_request(wal_pkg::OP_WRITE, $urandom);
    repeat (OPEN_LIMIT) send_request(wal_pkg::OP_END, $urandom);
  endtask

  // Random phases: mostly well-formed transactions, some noise and misuse.
  task automatic test_random();
    int r;
    for (int p = 0; p < 6; p++) begin
      drain_results();
      quiet = (p == 0);
      case (p)
        1: set_config(32'hFFFF_FFFF, 64, 1, 4);
        3: set_config(32'h0000_0000, 20, 2, 1);
        default: set_config($urandom, $urandom_range(12, 64),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(1, 63)
                                                        : $urandom_range(1, 6),
                            $urandom_range(1, 4));
      endcase
      for (int k = 0; k < 9; k++) begin
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0) drain_results();
        if (r < 4) begin
          send_request(2'($urandom_range(0, 3)), $urandom);
        end else if (jr_open == 0) begin
          if (r < 85) send_request(wal_pkg::OP_BEGIN, $urandom);
          else if (r < 93) send_request(wal_pkg::OP_WRITE, pick_block());
          else send_request(wal_pkg::OP_END, $urandom);
        end else begin
          if (r < 18) send_request(wal_pkg::OP_BEGIN, $urandom);
          else if (r < 72) send_request(wal_pkg::OP_WRITE, pick_block());
          else send_request(wal_pkg::OP_END, $urandom);
        end
      end
    end
    quiet = 1'b0;
  endtask

  // Random stalls on the result side.
  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = idle_len() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s differs, expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  // Compare every word taken from the block with the oldest prediction.
  always @(posedge clk) begin : check_words
    log_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: word with no prediction, expected none, got status %0d command %0d",
                   $time, out_status, out_command);
      end else begin
        w = pending_words.pop_front();
        check_field("status", 32'(w.status), 32'(out_status));
        check_field("command", 32'(w.command), 32'(out_command));
        check_field("src_block", w.src_block, out_src_block);
        check_field("dst_block", w.dst_block, out_dst_block);
        check_field("entry_count", 32'(w.entry_count), 32'(out_entry_count));
        check_field("pin_new", 32'(w.pin_new), 32'(out_pin_new));
        check_field("unpin", 32'(w.unpin), 32'(out_unpin));
        check_field("last", 32'(w.last), 32'(out_last));
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped at the cycle limit, %0d words still outstanding",
               $time, pending_words.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_wait_and_full();
    test_table_depth();
    test_open_saturation();
    test_random();
    drain_results();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests under reset, extreme and random register settings.",
             items_sent);
    $display("Checked %0d result words including %0d commit runs, %0d errors.",
             words_seen, commit_runs, err_count);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/wal_pkg.sv
design/wal_ram.sv
design/wal_datapath.sv
design/wal_ctrl.sv
design/write_ahead_log_tracker.sv
tb/write_ahead_log_tracker_tb.sv
